[hw/rtl/whm_pkg.sv]
// Shared types and constants for the windowed trend health monitor.
// No dependencies; imported by the top level, the arithmetic unit and the checker.
package whm_pkg;

	// arithmetic unit operation codes
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_CEILING = 2'd0;
	localparam logic [1:0] CFG_GROWTH  = 2'd1;
	localparam logic [1:0] CFG_WINDOW  = 2'd2;

	// result codes
	localparam logic [1:0] TREND_STABLE  = 2'd0;
	localparam logic [1:0] TREND_RISING  = 2'd1;
	localparam logic [1:0] TREND_FALLING = 2'd2;
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_WARNING  = 2'd1;
	localparam logic [1:0] STATUS_CRITICAL = 2'd2;

	localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
	localparam logic [31:0] USEC_PER_HOUR = 32'd3600000000;
	localparam logic signed [32:0] TREND_BAND = 33'sd1024;

	// ceil(2^68 / 10^6): (span * UPTIME_RECIP) >> 68 is exact for any 48-bit span
	localparam logic [48:0] UPTIME_RECIP = 49'h1_0C6F_7A0B_5ED9;
	localparam int          UPTIME_SHIFT = 68;

	localparam logic [31:0] SLOPE_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SLOPE_MIN = 32'h8000_0000;

	typedef struct packed {
		logic go;
		logic op;
	} mdu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} mdu_rsp_t;

endpackage

[hw/rtl/windowed_trend_health_monitor_core.sv]
// Windowed memory trend health monitor, top level.
// Depends on whm_pkg, whm_ring and whm_mdu.
//
// Each sample transaction (time in usec, level in kB) enters a ring of the last
// window_length samples; the block then fits a least-squares line over the
// ring with exact integer sums and returns one result transaction: slope in
// kB/h (truncated toward zero, saturated to 32 bits), trend, status, uptime in
// seconds and the window fill. All wide arithmetic runs on one shared
// bit-serial multiply/divide unit, so s_tready is high only while the
// sequencer is idle. A multiply ends once the remaining bits of its second
// operand are zero; the slope division steps through all W numerator bits,
// where W = 106 + 2*clog2(WINDOW_MAX+1) is the arithmetic width (W = 120 at
// WINDOW_MAX = 64). With fewer than two samples only the uptime is computed
// before the result is formed. A finished result sits in the output register
// while the next sample may be taken.
module windowed_trend_health_monitor_core #(
	parameter int WINDOW_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // time_usec[47:0], level_kb[71:48]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // slope[31:0], trend[33:32], status[35:34],
	                               // uptime[64:36], samples_held[71:65]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import whm_pkg::*;

	localparam int NB  = $clog2(WINDOW_MAX + 1);
	localparam int AW  = $clog2(WINDOW_MAX);
	localparam int W   = 106 + 2 * NB;
	localparam int SXW = 48 + NB;
	localparam int SYW = 24 + NB;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_UPT  = 4'd1;
	localparam logic [3:0] ST_RD   = 4'd2;
	localparam logic [3:0] ST_GET  = 4'd3;
	localparam logic [3:0] ST_MXX  = 4'd4;
	localparam logic [3:0] ST_MXY  = 4'd5;
	localparam logic [3:0] ST_D1   = 4'd6;
	localparam logic [3:0] ST_D2   = 4'd7;
	localparam logic [3:0] ST_AM   = 4'd8;
	localparam logic [3:0] ST_BM   = 4'd9;
	localparam logic [3:0] ST_HR   = 4'd10;
	localparam logic [3:0] ST_DV   = 4'd11;
	localparam logic [3:0] ST_FIN  = 4'd12;

	// config
	logic [23:0] ceil_q, grow_q;
	logic [6:0]  wlen_q;

	// ring bookkeeping
	logic [AW-1:0] head_q, idx_q;
	logic [NB-1:0] count_q, k_q;
	logic [47:0]   first_q;
	logic          started_q;

	logic [3:0]  state_q;
	logic        pend_q;
	logic [47:0] t_q, t0_q, x_q;
	logic [23:0] y_q, yk_q;
	logic        full_q;

	logic [SXW-1:0] sx_q;
	logic [SYW-1:0] sy_q;
	logic [W-1:0]   sxx_q, sxy_q, d1_q, a_q, mag_q;
	logic           neg_q;
	logic [28:0]    uptime_q;
	logic [31:0]    slope_q;

	logic        m_tvalid_q;
	logic [71:0] m_data_q;

	// ring
	logic [71:0] rdata;
	logic        accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	whm_ring #(.DEPTH(WINDOW_MAX), .AW(AW), .DW(72)) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (head_q),
		.wdata (s_tdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// effective length and next ring pointers
	logic [NB-1:0] len, cnt_inc, count_nx;
	logic [AW-1:0] head_nx;
	logic [NB:0]   oldest_w;

	always_comb begin
		if (wlen_q == 7'd0) begin
			len = NB'(1);
		end else if (32'(wlen_q) > WINDOW_MAX) begin
			len = NB'(WINDOW_MAX);
		end else begin
			len = NB'(wlen_q);
		end
		cnt_inc  = (count_q < NB'(WINDOW_MAX)) ? count_q + 1'b1 : count_q;
		count_nx = (cnt_inc > len) ? len : cnt_inc;
		head_nx  = (head_q == AW'(WINDOW_MAX - 1)) ? '0 : head_q + 1'b1;
		oldest_w = (NB+1)'(head_nx)
		         + (((NB+1)'(head_nx) < (NB+1)'(count_nx)) ? (NB+1)'(WINDOW_MAX) : '0)
		         - (NB+1)'(count_nx);
	end

	// time since the first sample, modulo 2^48
	logic [47:0] dt;
	assign dt = t_q - first_q;

	// shared arithmetic unit operand select
	mdu_req_t    req;
	mdu_rsp_t    rsp;
	logic [W-1:0] op_a, op_b, op_acc, prod;
	logic [31:0]  quo;

	always_comb begin
		req.go = 1'b0;
		req.op = OP_MUL;
		op_a   = '0;
		op_b   = '0;
		op_acc = '0;
		case (state_q)
			ST_UPT: begin
				// seconds by reciprocal multiply, quotient in the upper product bits
				req.go = !pend_q;
				op_a   = W'(dt);
				op_b   = W'(UPTIME_RECIP);
			end
			ST_MXX: begin
				req.go = !pend_q;
				op_a   = W'(x_q);
				op_b   = W'(x_q);
				op_acc = sxx_q;
			end
			ST_MXY: begin
				req.go = !pend_q;
				op_a   = W'(x_q);
				op_b   = W'(yk_q);
				op_acc = sxy_q;
			end
			ST_D1: begin
				req.go = !pend_q;
				op_a   = sxx_q;
				op_b   = W'(count_q);
			end
			ST_D2: begin
				req.go = !pend_q;
				op_a   = W'(sx_q);
				op_b   = W'(sx_q);
			end
			ST_AM: begin
				req.go = !pend_q;
				op_a   = sxy_q;
				op_b   = W'(count_q);
			end
			ST_BM: begin
				req.go = !pend_q;
				op_a   = W'(sx_q);
				op_b   = W'(sy_q);
			end
			ST_HR: begin
				req.go = !pend_q;
				op_a   = mag_q;
				op_b   = W'(USEC_PER_HOUR);
			end
			ST_DV: begin
				req.go = !pend_q;
				req.op = OP_DIV;
				op_a   = mag_q;
				op_b   = d1_q;
			end
			default: begin
				req.go = 1'b0;
			end
		endcase
	end

	whm_mdu #(.W(W)) u_mdu (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.a        (op_a),
		.b        (op_b),
		.acc_init (op_acc),
		.rsp      (rsp),
		.prod     (prod),
		.quo      (quo)
	);

	// per-sample offset from the oldest held time; the oldest itself is zero
	logic [47:0] xk;
	assign xk = (k_q == '0) ? 48'd0 : rdata[47:0] - t0_q;

	// magnitude of n*Sxy - Sx*Sy when the second product returns
	logic         bneg;
	logic [W-1:0] bmag;
	assign bneg = a_q < prod;
	assign bmag = bneg ? prod - a_q : a_q - prod;

	// saturated, truncated slope from the final quotient
	logic [31:0] slope_fin;
	always_comb begin
		if (rsp.sat) begin
			slope_fin = neg_q ? SLOPE_MIN : SLOPE_MAX;
		end else if (!neg_q) begin
			slope_fin = (quo > SLOPE_MAX) ? SLOPE_MAX : quo;
		end else begin
			slope_fin = (quo > SLOPE_MIN) ? SLOPE_MIN : 32'd0 - quo;
		end
	end

	// trend from the reported slope; status from the level, the ceiling and the slope
	logic signed [32:0] slope_s;
	logic [1:0]         trend, status;
	always_comb begin
		slope_s = $signed({slope_q[31], slope_q});
		if (slope_s > TREND_BAND) begin
			trend = TREND_RISING;
		end else if (slope_s < -TREND_BAND) begin
			trend = TREND_FALLING;
		end else begin
			trend = TREND_STABLE;
		end
		if (y_q > ceil_q) begin
			status = STATUS_CRITICAL;
		end else if (full_q && slope_s > $signed({9'd0, grow_q})) begin
			status = STATUS_WARNING;
		end else begin
			status = STATUS_OK;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q <= 24'd1048576;
			grow_q <= 24'd10240;
			wlen_q <= 7'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CEILING: ceil_q <= cfg_data;
				CFG_GROWTH:  grow_q <= cfg_data;
				CFG_WINDOW:  wlen_q <= cfg_data[6:0];
				default:     ceil_q <= ceil_q;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_q     <= 1'b0;
			head_q     <= '0;
			count_q    <= '0;
			first_q    <= '0;
			started_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output register: loaded from FIN when free or being taken
			if (state_q == ST_FIN && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (rsp.done) begin
				pend_q <= 1'b0;
			end else if (req.go) begin
				pend_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q    <= head_nx;
						count_q   <= count_nx;
						started_q <= 1'b1;
						if (!started_q) begin
							first_q <= s_tdata[47:0];
						end
						state_q <= ST_UPT;
					end
				end
				ST_UPT: begin
					if (rsp.done) begin
						state_q <= (count_q < NB'(2)) ? ST_FIN : ST_RD;
					end
				end
				ST_RD:  state_q <= ST_GET;
				ST_GET: state_q <= ST_MXX;
				ST_MXX: begin
					if (rsp.done) state_q <= ST_MXY;
				end
				ST_MXY: begin
					if (rsp.done) begin
						state_q <= (k_q + 1'b1 == count_q) ? ST_D1 : ST_RD;
					end
				end
				ST_D1: begin
					if (rsp.done) state_q <= ST_D2;
				end
				ST_D2: begin
					if (rsp.done) state_q <= (d1_q <= prod) ? ST_FIN : ST_AM;
				end
				ST_AM: begin
					if (rsp.done) state_q <= ST_BM;
				end
				ST_BM: begin
					if (rsp.done) state_q <= ST_HR;
				end
				ST_HR: begin
					if (rsp.done) state_q <= ST_DV;
				end
				ST_DV: begin
					if (rsp.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					t_q     <= s_tdata[47:0];
					y_q     <= s_tdata[71:48];
					full_q  <= count_nx >= len;
					idx_q   <= oldest_w[AW-1:0];
					k_q     <= '0;
					sx_q    <= '0;
					sy_q    <= '0;
					sxx_q   <= '0;
					sxy_q   <= '0;
					slope_q <= '0;
				end
			end
			ST_UPT: begin
				if (rsp.done) uptime_q <= prod[UPTIME_SHIFT +: 29];
			end
			ST_GET: begin
				if (k_q == '0) begin
					t0_q <= rdata[47:0];
				end
				x_q  <= xk;
				yk_q <= rdata[71:48];
				sx_q <= sx_q + SXW'(xk);
				sy_q <= sy_q + SYW'(rdata[71:48]);
			end
			ST_MXX: begin
				if (rsp.done) sxx_q <= prod;
			end
			ST_MXY: begin
				if (rsp.done) begin
					sxy_q <= prod;
					k_q   <= k_q + 1'b1;
					idx_q <= (idx_q == AW'(WINDOW_MAX - 1)) ? '0 : idx_q + 1'b1;
				end
			end
			ST_D1: begin
				if (rsp.done) d1_q <= prod;
			end
			ST_D2: begin
				// denominator n*Sxx - Sx^2 kept in d1_q
				if (rsp.done) d1_q <= d1_q - prod;
			end
			ST_AM: begin
				if (rsp.done) a_q <= prod;
			end
			ST_BM: begin
				if (rsp.done) begin
					neg_q <= bneg;
					mag_q <= bmag;
				end
			end
			ST_HR: begin
				if (rsp.done) mag_q <= prod;
			end
			ST_DV: begin
				if (rsp.done) slope_q <= slope_fin;
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					m_data_q <= {7'(count_q), uptime_q, status, trend, slope_q};
				end
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

endmodule

[hw/rtl/whm_ring.sv]
// Sample ring storage: one write port, one registered read port.
// No dependencies.
module whm_ring #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 72
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/whm_mdu.sv]
// Iterative multiply-accumulate / divide unit, one bit per cycle.
// Depends on whm_pkg for request/response types and op codes.
module whm_mdu #(
	parameter int W = 120
) (
	input  logic              clk,
	input  logic              arst_n,
	input  whm_pkg::mdu_req_t req,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	input  logic [W-1:0]      acc_init,
	output whm_pkg::mdu_rsp_t rsp,
	output logic [W-1:0]      prod,
	output logic [31:0]       quo
);
	import whm_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic          busy_q, done_q, op_q, sat_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q, mc_q, mp_q, rem_q;
	logic [31:0]   q_q;

	logic [W-1:0] rem_sh, diff, sum;
	logic         ge;

	// mc holds the multiplicand (mul) or the shifting numerator (div),
	// mp holds the multiplier (mul) or the divisor (div)
	assign rem_sh = {rem_q[W-2:0], mc_q[W-1]};
	assign ge     = rem_sh >= mp_q;
	assign diff   = rem_sh - mp_q;
	assign sum    = acc_q + mc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.go) begin
					busy_q <= 1'b1;
				end
			end else if (op_q == OP_MUL) begin
				if (mp_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (req.go) begin
				op_q  <= req.op;
				acc_q <= acc_init;
				mc_q  <= a;
				mp_q  <= b;
				rem_q <= '0;
				q_q   <= '0;
				sat_q <= 1'b0;
				cnt_q <= CW'(W);
			end
		end else if (op_q == OP_MUL) begin
			if (mp_q != '0) begin
				if (mp_q[0]) begin
					acc_q <= sum;
				end
				mc_q <= mc_q << 1;
				mp_q <= mp_q >> 1;
			end
		end else begin
			rem_q <= ge ? diff : rem_sh;
			q_q   <= {q_q[30:0], ge};
			sat_q <= sat_q | q_q[31];
			mc_q  <= mc_q << 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign prod     = acc_q;
	assign quo      = q_q;

endmodule

[hw/rtl/whm_checker.sv]
// Port-level checks for the trend health monitor, bound to the top level.
// Depends on whm_pkg for result codes.
module whm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);
	import whm_pkg::*;

	// result stays offered until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// sequencer is busy right after taking a sample
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sample accepted while working");

	// a result always reflects at least the sample that caused it
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:65] != 7'd0)
		else $error("empty window in result");

	// warning only comes with a positive slope
	a_warn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35:34] == STATUS_WARNING |-> !m_tdata[31] && m_tdata[31:0] != 32'd0)
		else $error("warning without growth");

endmodule

bind windowed_trend_health_monitor_core whm_checker u_whm_checker (.*);
